/* design/uartrx_pkg.sv */
// ----------------------------------------------------------------------------
// uartrx_pkg
// Types and constants shared by the UART register block with receive FIFO.
// ----------------------------------------------------------------------------
package uartrx_pkg;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_LINE  = 2'd2;

  localparam logic [9:0] ADDR_SR  = 10'h000;
  localparam logic [9:0] ADDR_DR  = 10'h004;
  localparam logic [9:0] ADDR_BRR = 10'h008;
  localparam logic [9:0] ADDR_CR1 = 10'h00C;
  localparam logic [9:0] ADDR_CR2 = 10'h010;
  localparam logic [9:0] ADDR_CR3 = 10'h014;

  localparam int CR1_UE     = 13;
  localparam int CR1_TXEIE  = 7;
  localparam int CR1_TCIE   = 6;
  localparam int CR1_RXNEIE = 5;
  localparam int CR1_RE     = 2;

  localparam int SR_TXE  = 7;
  localparam int SR_TC   = 6;
  localparam int SR_RXNE = 5;
  localparam int SR_ORE  = 3;

  localparam int SPACE_W = 9;

  typedef struct packed {
    logic [SPACE_W-1:0] rx_space;
    logic               rx_dropped;
    logic               irq_level;
    logic [7:0]         tx_byte;
    logic               tx_valid;
    logic [31:0]        read_data;
  } result_t;

endpackage

/* design/uartrx_out_buf.sv */
// ----------------------------------------------------------------------------
// uartrx_out_buf
// Output register with a skid stage, so a result can wait while the next
// transfer is taken on the input side.
// ----------------------------------------------------------------------------
module uartrx_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  uartrx_pkg::result_t in_res,
  output logic               out_valid,
  input  logic               out_ready,
  output uartrx_pkg::result_t out_res
);

  logic                main_v_r;
  logic                skid_v_r;
  uartrx_pkg::result_t main_r;
  uartrx_pkg::result_t skid_r;
  logic                push;

  assign in_ready  = !skid_v_r;
  assign push      = in_valid && !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= in_res;
      end
    end else if (push) begin
      skid_r <= in_res;
    end
  end

endmodule

/* design/uart_registers_with_rx_buffer_core.sv */
// ----------------------------------------------------------------------------
// uart_registers_with_rx_buffer_core
// UART register file (SR, DR, BRR, CR1-3) with a receive ring FIFO.
// ----------------------------------------------------------------------------
// One item is taken every clock while in_tready is high and gives one result.
// Register state and FIFO pointers update in the cycle of the transfer; the
// byte moved into DR from the FIFO leaves the memory read port in the next
// cycle and is bypassed to a DR read in that cycle, so the rate stays at one
// per clock. in_tready drops only while both the output register and its
// skid stage hold results. The FIFO memory needs no clearing pass after reset.
module uart_registers_with_rx_buffer_core #(
  parameter int RX_FIFO_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // address[9:0], write_data[41:10], rx_byte[49:42]
  input  logic [1:0]  in_tuser,  // action[1:0]
  input  logic        in_tlast,  // rx_chunk_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata  // read_data[31:0], tx_valid[32], tx_byte[40:33],
                                 // irq_level[41], rx_dropped[42], rx_space[51:43]
);

  localparam int FW = $clog2(RX_FIFO_DEPTH + 1);
  localparam int HW = $clog2(RX_FIFO_DEPTH);
  localparam int PW = FW + 1;
  localparam logic [FW-1:0] DEPTH_F = FW'(RX_FIFO_DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(RX_FIFO_DEPTH);
  localparam logic [HW-1:0] LAST_H  = HW'(RX_FIFO_DEPTH - 1);
  localparam int SPACE_PAD = uartrx_pkg::SPACE_W;

  logic [7:0]    data_reg_r;
  logic [15:0]   baud_r, baud_nxt;
  logic [13:0]   cr1_r, cr1_nxt;
  logic [31:0]   cr2_r, cr2_nxt;
  logic [31:0]   cr3_r, cr3_nxt;
  logic          txe_r, txe_nxt;
  logic          tc_r, tc_nxt;
  logic          rxne_r, rxne_nxt;
  logic          ore_r, ore_nxt;
  logic          armed_r, armed_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [HW-1:0] head_r, head_nxt;
  logic          pend_r, pend_nxt;
  logic          fwd_r, fwd_nxt;
  logic [7:0]    fwd_byte_r;

  logic [7:0]    fifo_mem [RX_FIFO_DEPTH];
  logic [7:0]    mem_q;

  logic          in_fire;
  logic [1:0]    action;
  logic [9:0]    address;
  logic [31:0]   write_data;
  logic [7:0]    rx_byte;
  logic [7:0]    data_now;
  logic          rx_en;
  logic          push;
  logic          pop_req;
  logic [FW-1:0] fill_push;
  logic [PW-1:0] pos_sum;
  logic [PW-1:0] pos_wrap;
  logic [HW-1:0] wr_addr;
  logic [FW-1:0] space;
  logic [FW+SPACE_PAD-1:0] space_ext;

  uartrx_pkg::result_t res;

  assign in_fire    = in_tvalid && in_tready;
  assign action     = in_tuser;
  assign address    = in_tdata[9:0];
  assign write_data = in_tdata[41:10];
  assign rx_byte    = in_tdata[49:42];

  assign data_now = pend_r ? (fwd_r ? fwd_byte_r : mem_q) : data_reg_r;
  assign rx_en    = cr1_r[uartrx_pkg::CR1_UE] && cr1_r[uartrx_pkg::CR1_RE];

  assign pos_sum  = PW'(head_r) + PW'(fill_r);
  assign pos_wrap = (pos_sum >= DEPTH_P) ? (pos_sum - DEPTH_P) : pos_sum;
  assign wr_addr  = pos_wrap[HW-1:0];

  always_comb begin
    baud_nxt  = baud_r;
    cr1_nxt   = cr1_r;
    cr2_nxt   = cr2_r;
    cr3_nxt   = cr3_r;
    txe_nxt   = txe_r;
    tc_nxt    = tc_r;
    rxne_nxt  = rxne_r;
    ore_nxt   = ore_r;
    armed_nxt = armed_r;
    head_nxt  = head_r;
    pend_nxt  = 1'b0;
    fwd_nxt   = 1'b0;
    push      = 1'b0;
    pop_req   = 1'b0;
    res       = '0;
    if (in_fire) begin
      case (action)
        uartrx_pkg::ACT_READ: begin
          case (address)
            uartrx_pkg::ADDR_SR: begin
              res.read_data[uartrx_pkg::SR_TXE]  = txe_r;
              res.read_data[uartrx_pkg::SR_TC]   = tc_r;
              res.read_data[uartrx_pkg::SR_RXNE] = rxne_r;
              res.read_data[uartrx_pkg::SR_ORE]  = ore_r;
              armed_nxt = 1'b1;
            end
            uartrx_pkg::ADDR_DR: begin
              if (ore_r && armed_r) begin
                ore_nxt = 1'b0;
              end
              res.read_data = {24'd0, data_now};
              rxne_nxt = 1'b0;
              pop_req  = 1'b1;
            end
            uartrx_pkg::ADDR_BRR: res.read_data = {16'd0, baud_r};
            uartrx_pkg::ADDR_CR1: res.read_data = {18'd0, cr1_r};
            uartrx_pkg::ADDR_CR2: res.read_data = cr2_r;
            uartrx_pkg::ADDR_CR3: res.read_data = cr3_r;
            default: res.read_data = '0;
          endcase
        end
        uartrx_pkg::ACT_WRITE: begin
          case (address)
            uartrx_pkg::ADDR_SR: begin
              if (!write_data[uartrx_pkg::SR_TC]) begin
                tc_nxt = 1'b0;
              end
              if (!write_data[uartrx_pkg::SR_RXNE]) begin
                rxne_nxt = 1'b0;
              end
            end
            uartrx_pkg::ADDR_DR: begin
              res.tx_valid = 1'b1;
              res.tx_byte  = write_data[7:0];
              txe_nxt      = 1'b1;
              tc_nxt       = 1'b1;
            end
            uartrx_pkg::ADDR_BRR: baud_nxt = write_data[15:0];
            uartrx_pkg::ADDR_CR1: cr1_nxt  = write_data[13:0];
            uartrx_pkg::ADDR_CR2: cr2_nxt  = write_data;
            uartrx_pkg::ADDR_CR3: cr3_nxt  = write_data;
            default: ;
          endcase
        end
        uartrx_pkg::ACT_LINE: begin
          if (!rx_en) begin
            res.rx_dropped = 1'b1;
          end else begin
            if (fill_r == DEPTH_F) begin
              res.rx_dropped = 1'b1;
            end else begin
              push = 1'b1;
            end
            pop_req = in_tlast;
          end
        end
        default: ;
      endcase
    end

    fill_push = fill_r + FW'(push);
    fill_nxt  = fill_push;
    if (pop_req && (fill_push != '0)) begin
      fill_nxt = fill_push - FW'(1);
      head_nxt = (head_r == LAST_H) ? '0 : head_r + HW'(1);
      if (rx_en) begin
        if (rxne_nxt) begin
          ore_nxt   = 1'b1;
          armed_nxt = 1'b0;
        end
        rxne_nxt = 1'b1;
        pend_nxt = 1'b1;
        fwd_nxt  = push && (fill_r == '0);
      end
    end

    space         = DEPTH_F - fill_nxt;
    space_ext     = {{SPACE_PAD{1'b0}}, space};
    res.rx_space  = space_ext[uartrx_pkg::SPACE_W-1:0];
    res.irq_level = (cr1_nxt[uartrx_pkg::CR1_TXEIE] && txe_nxt) ||
                    (cr1_nxt[uartrx_pkg::CR1_TCIE] && tc_nxt) ||
                    (cr1_nxt[uartrx_pkg::CR1_RXNEIE] && (rxne_nxt || ore_nxt));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_addr] <= rx_byte;
    end
    mem_q <= fifo_mem[head_r];
  end

  always_ff @(posedge clk) begin
    fwd_byte_r <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_reg_r <= '0;
      baud_r     <= '0;
      cr1_r      <= '0;
      cr2_r      <= '0;
      cr3_r      <= '0;
      txe_r      <= 1'b1;
      tc_r       <= 1'b1;
      rxne_r     <= 1'b0;
      ore_r      <= 1'b0;
      armed_r    <= 1'b0;
      fill_r     <= '0;
      head_r     <= '0;
      pend_r     <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      data_reg_r <= data_now;
      baud_r     <= baud_nxt;
      cr1_r      <= cr1_nxt;
      cr2_r      <= cr2_nxt;
      cr3_r      <= cr3_nxt;
      txe_r      <= txe_nxt;
      tc_r       <= tc_nxt;
      rxne_r     <= rxne_nxt;
      ore_r      <= ore_nxt;
      armed_r    <= armed_nxt;
      fill_r     <= fill_nxt;
      head_r     <= head_nxt;
      pend_r     <= pend_nxt;
      fwd_r      <= fwd_nxt;
    end
  end

  uartrx_pkg::result_t out_res;

  uartrx_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_fire),
    .in_ready  (in_tready),
    .in_res    (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'd0, out_res};

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_F)
    else $error("rx fill beyond depth");

  a_pend_origin: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(in_fire))
    else $error("DR load pending without a transfer");

  a_fwd_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (pend_r && $past(fill_r) == '0))
    else $error("forward taken with non-empty FIFO");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result held");
`endif

endmodule

/* test/uart_registers_with_rx_buffer_core_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_registers_with_rx_buffer_core_chk
// Watches both streams of the UART register block, keeps its own copy of the
// registers, flags and receive ring, works out the reply to every accepted
// item and compares each returned reply with the oldest one outstanding.
// ----------------------------------------------------------------------------
module uart_registers_with_rx_buffer_core_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  output int          errors,
  output int          backlog
);

  localparam int FIFO_DEPTH = 256;

  logic [7:0]  dr_q;
  logic [15:0] brr_q;
  logic [13:0] cr1_q;
  logic [31:0] cr2_q;
  logic [31:0] cr3_q;
  logic        txe_q;
  logic        tc_q;
  logic        rxne_q;
  logic        ore_q;
  logic        sr_seen_q;
  logic [7:0]  rxq_mem [FIFO_DEPTH];
  int          rxq_fill;
  int          rxq_head;

  uartrx_pkg::result_t due_replies [$];
  uartrx_pkg::result_t reply;
  uartrx_pkg::result_t want;
  uartrx_pkg::result_t seen;

  initial begin
    errors  = 0;
    backlog = 0;
  end

  function automatic bit rx_on();
    return cr1_q[uartrx_pkg::CR1_UE] && cr1_q[uartrx_pkg::CR1_RE];
  endfunction

  // head of the ring into DR; discarded while the receiver is off
  task automatic load_dr();
    logic [7:0] b;
    if (rxq_fill == 0) return;
    b = rxq_mem[rxq_head];
    rxq_head = (rxq_head + 1) % FIFO_DEPTH;
    rxq_fill--;
    if (rx_on()) begin
      if (rxne_q) begin
        ore_q     = 1'b1;
        sr_seen_q = 1'b0;
      end
      dr_q   = b;
      rxne_q = 1'b1;
    end
  endtask

  task automatic uart_item(input logic [1:0] act, input logic [9:0] addr,
                           input logic [31:0] wd, input logic [7:0] rb,
                           input logic chunk_end, output uartrx_pkg::result_t r);
    r = '0;
    case (act)
      uartrx_pkg::ACT_READ: begin
        case (addr)
          uartrx_pkg::ADDR_SR: begin
            r.read_data[uartrx_pkg::SR_TXE]  = txe_q;
            r.read_data[uartrx_pkg::SR_TC]   = tc_q;
            r.read_data[uartrx_pkg::SR_RXNE] = rxne_q;
            r.read_data[uartrx_pkg::SR_ORE]  = ore_q;
            sr_seen_q = 1'b1;
          end
          uartrx_pkg::ADDR_DR: begin
            if (ore_q && sr_seen_q) ore_q = 1'b0;
            r.read_data = {24'd0, dr_q};
            rxne_q = 1'b0;
            load_dr();
          end
          uartrx_pkg::ADDR_BRR: r.read_data = {16'd0, brr_q};
          uartrx_pkg::ADDR_CR1: r.read_data = {18'd0, cr1_q};
          uartrx_pkg::ADDR_CR2: r.read_data = cr2_q;
          uartrx_pkg::ADDR_CR3: r.read_data = cr3_q;
          default: ;
        endcase
      end
      uartrx_pkg::ACT_WRITE: begin
        case (addr)
          uartrx_pkg::ADDR_SR: begin
            if (!wd[uartrx_pkg::SR_TC])   tc_q   = 1'b0;
            if (!wd[uartrx_pkg::SR_RXNE]) rxne_q = 1'b0;
          end
          uartrx_pkg::ADDR_DR: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = wd[7:0];
            txe_q = 1'b1;
            tc_q  = 1'b1;
          end
          uartrx_pkg::ADDR_BRR: brr_q = wd[15:0];
          uartrx_pkg::ADDR_CR1: cr1_q = wd[13:0];
          uartrx_pkg::ADDR_CR2: cr2_q = wd;
          uartrx_pkg::ADDR_CR3: cr3_q = wd;
          default: ;
        endcase
      end
      uartrx_pkg::ACT_LINE: begin
        if (!rx_on()) begin
          r.rx_dropped = 1'b1;
        end else begin
          if (rxq_fill >= FIFO_DEPTH) begin
            r.rx_dropped = 1'b1;
          end else begin
            rxq_mem[(rxq_head + rxq_fill) % FIFO_DEPTH] = rb;
            rxq_fill++;
          end
          if (chunk_end) load_dr();
        end
      end
      default: ;
    endcase
    r.irq_level = (cr1_q[uartrx_pkg::CR1_TXEIE] && txe_q) ||
                  (cr1_q[uartrx_pkg::CR1_TCIE] && tc_q) ||
                  (cr1_q[uartrx_pkg::CR1_RXNEIE] && (rxne_q || ore_q));
    r.rx_space  = (uartrx_pkg::SPACE_W)'(FIFO_DEPTH - rxq_fill);
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dr_q      = '0;
      brr_q     = '0;
      cr1_q     = '0;
      cr2_q     = '0;
      cr3_q     = '0;
      txe_q     = 1'b1;
      tc_q      = 1'b1;
      rxne_q    = 1'b0;
      ore_q     = 1'b0;
      sr_seen_q = 1'b0;
      rxq_fill  = 0;
      rxq_head  = 0;
      due_replies.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        uart_item(in_tuser, in_tdata[9:0], in_tdata[41:10], in_tdata[49:42],
                  in_tlast, reply);
        due_replies.push_back(reply);
      end
      if (out_tvalid && out_tready) begin
        seen = uartrx_pkg::result_t'(out_tdata[51:0]);
        if (due_replies.size() == 0) begin
          $display("%0t: reply with nothing outstanding: expected none, got %h",
                   $time, out_tdata);
          errors++;
        end else begin
          want = due_replies.pop_front();
          check_field("read_data",  want.read_data,  seen.read_data);
          check_field("tx_valid",   32'(want.tx_valid),   32'(seen.tx_valid));
          check_field("tx_byte",    32'(want.tx_byte),    32'(seen.tx_byte));
          check_field("irq_level",  32'(want.irq_level),  32'(seen.irq_level));
          check_field("rx_dropped", 32'(want.rx_dropped), 32'(seen.rx_dropped));
          check_field("rx_space",   32'(want.rx_space),   32'(seen.rx_space));
          check_field("padding",    '0,                   32'(out_tdata[55:52]));
        end
      end
    end
    backlog <= due_replies.size();
  end

endmodule

/* test/uart_registers_with_rx_buffer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_registers_with_rx_buffer_core_tb
// Drives register reads, writes and line bytes into the UART register block
// in random bursts, stalls the reply stream on its own pattern, floods the
// receive ring past full and drains it, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module uart_registers_with_rx_buffer_core_tb;

  localparam logic [1:0]  ACT_NONE    = 2'd3;
  localparam logic [9:0]  ADDR_GTPR   = 10'h018;
  localparam logic [9:0]  ADDR_BAD    = 10'h3FF;
  localparam logic [31:0] RX_ON_BITS  = (32'd1 << uartrx_pkg::CR1_UE) |
                                        (32'd1 << uartrx_pkg::CR1_RE);
  localparam int          ITEM_TARGET = 1550;
  localparam int          HOLD_CYCLES = 400;
  localparam int          STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  int          errors;
  int          backlog;
  int          sent;
  int          burst_left;
  int          idle_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  uart_registers_with_rx_buffer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  uart_registers_with_rx_buffer_core_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .backlog    (backlog)
  );

  // one transfer, with a random gap whenever a burst runs out
  task automatic send_item(input logic [1:0] act, input logic [9:0] addr,
                           input logic [31:0] wd, input logic [7:0] rb,
                           input logic chunk_end);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tlast  <= chunk_end;
    in_tdata  <= {6'd0, rb, wd, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic reg_read(input logic [9:0] addr);
    send_item(uartrx_pkg::ACT_READ, addr, $urandom, 8'($urandom), 1'($urandom));
  endtask

  task automatic reg_write(input logic [9:0] addr, input logic [31:0] wd);
    send_item(uartrx_pkg::ACT_WRITE, addr, wd, 8'($urandom), 1'($urandom));
  endtask

  task automatic line_byte(input logic [7:0] rb, input logic chunk_end);
    send_item(uartrx_pkg::ACT_LINE, 10'($urandom), $urandom, rb, chunk_end);
  endtask

  function automatic logic [9:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return uartrx_pkg::ADDR_SR;
      1: return uartrx_pkg::ADDR_DR;
      2: return uartrx_pkg::ADDR_BRR;
      3: return uartrx_pkg::ADDR_CR1;
      4: return uartrx_pkg::ADDR_CR2;
      5: return uartrx_pkg::ADDR_CR3;
      6: return ADDR_GTPR;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [31:0] pick_cr1();
    return ($urandom_range(0, 5) == 0) ? $urandom : ($urandom | RX_ON_BITS);
  endfunction

  // reply side: segments of varying stall density, one long hold-off
  initial begin
    int  seg_len;
    int  mode;
    int  xfers;
    bit  held;
    xfers = 0;
    held  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      seg_len = $urandom_range(20, 80);
      mode    = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk);
        if (out_tvalid && out_tready) xfers++;
        if (!held && xfers >= 500) begin
          held = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom);
          2: out_tready <= ($urandom_range(0, 4) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("** uart_registers_with_rx_buffer_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= uartrx_pkg::ACT_READ;
    in_tlast    <= 1'b0;
    out_tready  <= 1'b0;
    idle_cycles <= 0;
    sent        = 0;
    burst_left  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, disabled receiver, register masks and odd addresses
    reg_read(uartrx_pkg::ADDR_SR);
    reg_read(uartrx_pkg::ADDR_DR);
    line_byte(8'hFF, 1'b1);
    reg_write(uartrx_pkg::ADDR_BRR, '1);
    reg_write(uartrx_pkg::ADDR_CR1, '1);
    reg_write(uartrx_pkg::ADDR_CR2, '1);
    reg_write(uartrx_pkg::ADDR_CR3, '1);
    reg_write(ADDR_GTPR, '1);
    reg_write(ADDR_BAD, '1);
    reg_read(uartrx_pkg::ADDR_BRR);
    reg_read(uartrx_pkg::ADDR_CR1);
    reg_read(uartrx_pkg::ADDR_CR2);
    reg_read(uartrx_pkg::ADDR_CR3);
    reg_read(ADDR_GTPR);
    reg_read(ADDR_BAD);
    // fill, overrun, ORE kept without SR read, then cleared
    line_byte(8'h00, 1'b0);
    line_byte(8'hFF, 1'b1);
    line_byte(8'hA5, 1'b1);
    reg_read(uartrx_pkg::ADDR_DR);
    reg_read(uartrx_pkg::ADDR_SR);
    reg_read(uartrx_pkg::ADDR_DR);
    reg_write(uartrx_pkg::ADDR_DR, 32'hFFFF_FF5A);
    reg_write(uartrx_pkg::ADDR_SR, '0);
    reg_write(uartrx_pkg::ADDR_SR, '1);
    send_item(ACT_NONE, uartrx_pkg::ADDR_SR, '1, 8'hFF, 1'b1);
    // DR read with the receiver off still pops the ring
    line_byte(8'h3C, 1'b0);
    reg_write(uartrx_pkg::ADDR_CR1, '0);
    reg_read(uartrx_pkg::ADDR_DR);

    // ring past full, pause until drained out, then empty it by DR reads
    reg_write(uartrx_pkg::ADDR_CR1, $urandom | RX_ON_BITS);
    for (int i = 0; i < 270; i++) line_byte(8'($urandom), i == 269);
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    reg_read(uartrx_pkg::ADDR_SR);
    repeat (260) reg_read(uartrx_pkg::ADDR_DR);

    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: reg_write(uartrx_pkg::ADDR_CR1, pick_cr1());
        1, 2, 3: repeat ($urandom_range(1, 20))
                   line_byte(8'($urandom), $urandom_range(0, 3) == 0);
        4, 5: begin
          reg_read(uartrx_pkg::ADDR_SR);
          repeat ($urandom_range(1, 4)) reg_read(uartrx_pkg::ADDR_DR);
        end
        6, 7: send_item(2'($urandom_range(0, 3)), pick_addr(), $urandom,
                        8'($urandom), 1'($urandom));
        8: reg_write($urandom_range(0, 1) ? uartrx_pkg::ADDR_SR : uartrx_pkg::ADDR_DR,
                     $urandom);
        default: reg_write(pick_addr(), $urandom);
      endcase
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** uart_registers_with_rx_buffer_core: PASSED **");
    end else begin
      $display("** uart_registers_with_rx_buffer_core: FAILED **");
    end
    $finish;
  end

endmodule
